// ----- rtl/core/sst_pkg.sv -----
`timescale 1ns / 1ps

package sst_pkg;

  localparam int OPCODE_W = 2;
  localparam int KEY_W    = 10;
  localparam int ELEM_W   = 32;
  localparam int COUNT_W  = 9;

  typedef enum logic [1:0] {
    OP_GET    = 2'd0,
    OP_SET    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2,
    ST_RANGE  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SRC_ZERO  = 2'd0,
    SRC_VAL   = 2'd1,
    SRC_RDATA = 2'd2
  } src_t;

  typedef enum logic [2:0] {
    S_CLEAR    = 3'd0,
    S_IDLE     = 3'd1,
    S_DECIDE   = 3'd2,
    S_GET_DATA = 3'd3,
    S_RM_READ  = 3'd4,
    S_RM_MOVE  = 3'd5,
    S_RM_DROP  = 3'd6,
    S_DONE     = 3'd7
  } state_t;

  typedef struct packed {
    logic    capture;
    logic    clear_step;
    logic    set_hit;
    logic    set_new;
    logic    get_rd;
    logic    rm_rd;
    logic    rm_take;
    logic    rm_move;
    logic    rm_drop;
    logic    stage;
    status_t stage_status;
    src_t    stage_src;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic in_range;
    logic hit;
    logic full;
    logic clr_last;
    logic out_free;
  } stat_t;

endpackage

// ----- rtl/core/sst_channels.sv -----
`timescale 1ns / 1ps

interface sst_in_if;
  logic                         valid;
  logic                         ready;
  logic [sst_pkg::OPCODE_W-1:0] opcode;
  logic [sst_pkg::KEY_W-1:0]    key;
  logic [sst_pkg::ELEM_W-1:0]   element_value;

  modport source (output valid, output opcode, output key, output element_value, input ready);
  modport sink (input valid, input opcode, input key, input element_value, output ready);
endinterface

interface sst_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [sst_pkg::ELEM_W-1:0]  element_out;
  logic [sst_pkg::COUNT_W-1:0] entry_count;

  modport source (output valid, output status, output element_out, output entry_count,
                  input ready);
  modport sink (input valid, input status, input element_out, input entry_count,
                output ready);
endinterface

// ----- rtl/core/sst_ram.sv -----
`timescale 1ns / 1ps

module sst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/sst_ctrl.sv -----
`timescale 1ns / 1ps

module sst_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  sst_pkg::stat_t stat,
  output sst_pkg::cmd_t  cmd
);

  sst_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sst_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      sst_pkg::S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clr_last) begin
          state_nxt = sst_pkg::S_IDLE;
        end
      end
      sst_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = sst_pkg::S_DECIDE;
        end
      end
      sst_pkg::S_DECIDE: begin
        cmd.stage        = 1'b1;
        cmd.stage_status = sst_pkg::ST_OK;
        cmd.stage_src    = sst_pkg::SRC_ZERO;
        state_nxt        = sst_pkg::S_DONE;
        if (stat.op == sst_pkg::OP_NOP) begin
          cmd.stage_status = sst_pkg::ST_OK;
        end else if (!stat.in_range) begin
          cmd.stage_status = sst_pkg::ST_RANGE;
        end else begin
          unique case (stat.op)
            sst_pkg::OP_GET: begin
              if (stat.hit) begin
                cmd.stage   = 1'b0;
                cmd.get_rd  = 1'b1;
                state_nxt   = sst_pkg::S_GET_DATA;
              end else begin
                cmd.stage_status = sst_pkg::ST_ABSENT;
              end
            end
            sst_pkg::OP_SET: begin
              if (stat.hit) begin
                cmd.set_hit   = 1'b1;
                cmd.stage_src = sst_pkg::SRC_VAL;
              end else if (stat.full) begin
                cmd.stage_status = sst_pkg::ST_FULL;
              end else begin
                cmd.set_new   = 1'b1;
                cmd.stage_src = sst_pkg::SRC_VAL;
              end
            end
            sst_pkg::OP_REMOVE: begin
              if (stat.hit) begin
                cmd.stage  = 1'b0;
                cmd.rm_rd  = 1'b1;
                state_nxt  = sst_pkg::S_RM_READ;
              end else begin
                cmd.stage_status = sst_pkg::ST_ABSENT;
              end
            end
            default: begin
              cmd.stage_status = sst_pkg::ST_OK;
            end
          endcase
        end
      end
      sst_pkg::S_GET_DATA: begin
        cmd.stage        = 1'b1;
        cmd.stage_status = sst_pkg::ST_OK;
        cmd.stage_src    = sst_pkg::SRC_RDATA;
        state_nxt        = sst_pkg::S_DONE;
      end
      sst_pkg::S_RM_READ: begin
        // removed element arrives now, last entry is read next
        cmd.rm_take      = 1'b1;
        cmd.stage        = 1'b1;
        cmd.stage_status = sst_pkg::ST_OK;
        cmd.stage_src    = sst_pkg::SRC_RDATA;
        state_nxt        = sst_pkg::S_RM_MOVE;
      end
      sst_pkg::S_RM_MOVE: begin
        cmd.rm_move = 1'b1;
        state_nxt   = sst_pkg::S_RM_DROP;
      end
      sst_pkg::S_RM_DROP: begin
        cmd.rm_drop = 1'b1;
        state_nxt   = sst_pkg::S_DONE;
      end
      sst_pkg::S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = sst_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = sst_pkg::S_CLEAR;
      end
    endcase
  end

endmodule

// ----- rtl/core/sst_dp.sv -----
`timescale 1ns / 1ps

module sst_dp #(
  parameter int KEY_SPACE  = 1024,
  parameter int CAPACITY   = 256,
  parameter int ELEM_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sst_pkg::cmd_t                cmd,
  output sst_pkg::stat_t               stat,
  input  logic [sst_pkg::OPCODE_W-1:0] in_opcode,
  input  logic [sst_pkg::KEY_W-1:0]    in_key,
  input  logic [sst_pkg::ELEM_W-1:0]   in_element_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_status,
  output logic [sst_pkg::ELEM_W-1:0]   out_element_out,
  output logic [sst_pkg::COUNT_W-1:0]  out_entry_count
);

  localparam int KW = $clog2(KEY_SPACE);
  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = (ELEM_WIDTH < sst_pkg::ELEM_W) ? ELEM_WIDTH : sst_pkg::ELEM_W;

  sst_pkg::op_t               op_r;
  logic [sst_pkg::KEY_W-1:0]  key_r;
  logic [SW-1:0]              val_r;
  logic [IW-1:0]              idx_r;
  logic [sst_pkg::KEY_W-1:0]  moved_key_r;
  logic [CW-1:0]              count_r, count_nxt;
  logic [KW-1:0]              clr_cnt_r;
  sst_pkg::status_t           res_status_r;
  logic [SW-1:0]              res_elem_r, res_elem_nxt;
  logic                       out_valid_r;
  sst_pkg::status_t           out_status_r;
  logic [sst_pkg::ELEM_W-1:0] out_elem_r;
  logic [sst_pkg::COUNT_W-1:0] out_count_r;

  logic                       sp_we;
  logic [KW-1:0]              sp_waddr;
  logic [IW:0]                sp_wdata;
  logic [IW:0]                sp_rdata;
  logic                       el_we;
  logic [IW-1:0]              el_waddr;
  logic [SW-1:0]              el_wdata;
  logic [IW-1:0]              el_raddr;
  logic [SW-1:0]              el_rdata;
  logic                       ky_we;
  logic [IW-1:0]              ky_waddr;
  logic [sst_pkg::KEY_W-1:0]  ky_wdata;
  logic [sst_pkg::KEY_W-1:0]  ky_rdata;

  logic [IW-1:0]              slot;
  logic [IW-1:0]              last;

  assign slot = sp_rdata[IW-1:0];
  assign last = IW'(count_r - CW'(1));

  // sparse slot: valid bit above the dense index
  sst_ram #(.WIDTH(IW + 1), .DEPTH(KEY_SPACE)) u_sparse (
    .clk   (clk),
    .we    (sp_we),
    .waddr (sp_waddr),
    .wdata (sp_wdata),
    .raddr (KW'(in_key)),
    .rdata (sp_rdata)
  );

  sst_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_elems (
    .clk   (clk),
    .we    (el_we),
    .waddr (el_waddr),
    .wdata (el_wdata),
    .raddr (el_raddr),
    .rdata (el_rdata)
  );

  sst_ram #(.WIDTH(sst_pkg::KEY_W), .DEPTH(CAPACITY)) u_keys (
    .clk   (clk),
    .we    (ky_we),
    .waddr (ky_waddr),
    .wdata (ky_wdata),
    .raddr (last),
    .rdata (ky_rdata)
  );

  always_comb begin
    sp_we    = 1'b0;
    sp_waddr = KW'(key_r);
    sp_wdata = '0;
    if (cmd.clear_step) begin
      sp_we    = 1'b1;
      sp_waddr = clr_cnt_r;
    end else if (cmd.set_new) begin
      sp_we    = 1'b1;
      sp_wdata = {1'b1, IW'(count_r)};
    end else if (cmd.rm_move) begin
      // repoint the moved key before the removed key is dropped
      sp_we    = 1'b1;
      sp_waddr = KW'(moved_key_r);
      sp_wdata = {1'b1, idx_r};
    end else if (cmd.rm_drop) begin
      sp_we    = 1'b1;
    end
  end

  always_comb begin
    el_we    = 1'b0;
    el_waddr = slot;
    el_wdata = val_r;
    ky_we    = 1'b0;
    ky_waddr = IW'(count_r);
    ky_wdata = key_r;
    if (cmd.set_hit) begin
      el_we = 1'b1;
    end else if (cmd.set_new) begin
      el_we    = 1'b1;
      el_waddr = IW'(count_r);
      ky_we    = 1'b1;
    end else if (cmd.rm_move) begin
      el_we    = 1'b1;
      el_waddr = idx_r;
      el_wdata = el_rdata;
      ky_we    = 1'b1;
      ky_waddr = idx_r;
      ky_wdata = moved_key_r;
    end
  end

  assign el_raddr = cmd.rm_take ? last : slot;

  always_comb begin
    count_nxt = count_r;
    if (cmd.set_new) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.rm_drop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    case (cmd.stage_src)
      sst_pkg::SRC_VAL:   res_elem_nxt = val_r;
      sst_pkg::SRC_RDATA: res_elem_nxt = el_rdata;
      default:            res_elem_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.clear_step) begin
        clr_cnt_r <= clr_cnt_r + KW'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= sst_pkg::op_t'(in_opcode);
      key_r <= in_key;
      val_r <= SW'(in_element_value);
    end
    if (cmd.get_rd || cmd.rm_rd) begin
      idx_r <= slot;
    end
    if (cmd.rm_take) begin
      moved_key_r <= ky_rdata;
    end
    if (cmd.stage) begin
      res_status_r <= cmd.stage_status;
      res_elem_r   <= res_elem_nxt;
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_elem_r   <= sst_pkg::ELEM_W'(res_elem_r);
      out_count_r  <= sst_pkg::COUNT_W'(count_r);
    end
  end

  assign stat.op       = op_r;
  assign stat.in_range = (32'(key_r) < 32'(KEY_SPACE));
  assign stat.hit      = sp_rdata[IW] && (CW'(slot) < count_r);
  assign stat.full     = (count_r == CW'(CAPACITY));
  assign stat.clr_last = (clr_cnt_r == KW'(KEY_SPACE - 1));
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_element_out = out_elem_r;
  assign out_entry_count = out_count_r;

endmodule

// ----- rtl/core/sparse_set_table_unit.sv -----
`timescale 1ns / 1ps

// Sparse set with swap-with-last removal: keys map to a packed dense array of
// elements, one request in and one result beat out per request. After reset the
// block runs a clearing pass over the sparse table, one key per cycle, so it
// takes no request until every key is cleared. A request then runs through the
// decide and done states for set, out-of-range keys, unused opcodes and any get
// or remove of an absent key; a get that finds its key adds a data state and a
// remove that finds its key adds read, move and drop states, and done waits for
// the result register to drain; remove is the longest because the removed
// element and the last element share the one read port of the element memory,
// and the repoint and the absent mark share the sparse write port.
// One request is in flight at a time; a finished result waits in the output
// register while the next request is taken.
module sparse_set_table_unit #(
  parameter int KEY_SPACE  = 1024,
  parameter int CAPACITY   = 256,
  parameter int ELEM_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  sst_in_if.sink      in_bus,
  sst_out_if.source   out_bus
);

  sst_pkg::cmd_t  cmd;
  sst_pkg::stat_t stat;
  logic           in_ready;

  assign in_bus.ready = in_ready;

  sst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sst_dp #(
    .KEY_SPACE  (KEY_SPACE),
    .CAPACITY   (CAPACITY),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_opcode        (in_bus.opcode),
    .in_key           (in_bus.key),
    .in_element_value (in_bus.element_value),
    .out_valid        (out_bus.valid),
    .out_ready        (out_bus.ready),
    .out_status       (out_bus.status),
    .out_element_out  (out_bus.element_out),
    .out_entry_count  (out_bus.entry_count)
  );

`ifndef SYNTH
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_bus.valid && in_ready) |=> !in_ready)
    else $error("request taken while another is in flight");

  a_append_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.set_new |-> !stat.full)
    else $error("append into a full store");

  a_remove_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rm_rd |-> (stat.hit && stat.in_range && stat.op == sst_pkg::OP_REMOVE))
    else $error("remove started on an absent key");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> stat.out_free)
    else $error("result loaded over an untaken beat");
`endif

endmodule
